>>> rtl/slne_pkg.sv
// ----------------------------------------------------------------------------
// slne_pkg : shared types, constants and segment tables
// Command codes, microcode word layout, the microprogram, and the segment
// encoding tables for the two lines of the segment LCD.
// ----------------------------------------------------------------------------
package slne_pkg;

    // Command codes carried on the input channel
    localparam logic [1:0] CMD_DIGIT  = 2'd0;
    localparam logic [1:0] CMD_LETTER = 2'd1;
    localparam logic [1:0] CMD_NUMBER = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Largest numbers each line can show
    localparam logic [16:0] UPPER_MAX = 17'd9999;
    localparam logic [16:0] LOWER_MAX = 17'd99999;

    // x / 10 == (x * DIV10_MAGIC) >> DIV10_SHIFT for every 17-bit x
    localparam logic [19:0] DIV10_MAGIC = 20'd838861;
    localparam int          DIV10_SHIFT = 23;

    // ASCII codes used for the overflow word
    localparam logic [6:0] CHR_E = 7'h65;
    localparam logic [6:0] CHR_R = 7'h72;
    localparam logic [6:0] CHR_O = 7'h6F;
    localparam logic [16:0] CHR_A_LO = 17'h61;
    localparam logic [16:0] CHR_Z_LO = 17'h7A;

    // Micro-operations
    typedef enum logic [2:0] {
        OP_WAIT,     // take a new input beat, dispatch on command
        OP_DIGIT,    // emit one digit pattern at the requested slot
        OP_LETTER,   // emit one letter pattern at the requested slot
        OP_TEST,     // evaluate a branch condition, no write
        OP_NUMDIG,   // emit lowest decimal digit, divide value by ten
        OP_ERRCHR    // emit a fixed letter of the overflow word
    } op_t;

    // Branch conditions
    typedef enum logic [1:0] {
        COND_NONE,
        COND_OVER,   // number too large for the selected line
        COND_ZERO,   // remaining value is zero
        COND_DONE    // this digit was the last one
    } cond_t;

    typedef struct packed {
        op_t        op;
        cond_t      cond;
        logic [3:0] jump;   // taken when cond holds
        logic [3:0] next;   // fall-through
        logic [2:0] pos;    // fixed lower-line position for OP_ERRCHR
        logic [6:0] chr;    // fixed letter for OP_ERRCHR
        logic       last;   // fixed end-of-item flag for fixed writes
    } ucode_t;

    // Program entry points
    localparam logic [3:0] S_WAIT   = 4'd0;
    localparam logic [3:0] S_DIGIT  = 4'd1;
    localparam logic [3:0] S_LETTER = 4'd2;
    localparam logic [3:0] S_OVER   = 4'd3;
    localparam logic [3:0] S_ZERO   = 4'd4;
    localparam logic [3:0] S_NUMDIG = 4'd5;
    localparam logic [3:0] S_ERR    = 4'd6;
    localparam logic [3:0] S_END    = 4'd10;

    // Microprogram ROM
    function automatic ucode_t ucode_rom(input logic [3:0] step);
        ucode_t w;
        w = '{op: OP_WAIT, cond: COND_NONE, jump: S_WAIT, next: S_WAIT,
              pos: 3'd0, chr: 7'd0, last: 1'b0};
        unique case (step)
            S_WAIT:   w.op = OP_WAIT;
            S_DIGIT:  begin w.op = OP_DIGIT;  w.last = 1'b1; end
            S_LETTER: begin w.op = OP_LETTER; w.last = 1'b1; end
            S_OVER:
            begin
                w.op = OP_TEST; w.cond = COND_OVER; w.jump = S_ERR; w.next = S_ZERO;
            end
            S_ZERO:
            begin
                w.op = OP_TEST; w.cond = COND_ZERO; w.jump = S_WAIT; w.next = S_NUMDIG;
            end
            S_NUMDIG:
            begin
                w.op = OP_NUMDIG; w.cond = COND_DONE; w.jump = S_WAIT; w.next = S_NUMDIG;
            end
            4'd6:  begin w.op = OP_ERRCHR; w.pos = 3'd1; w.chr = CHR_E; w.next = 4'd7;  end
            4'd7:  begin w.op = OP_ERRCHR; w.pos = 3'd2; w.chr = CHR_R; w.next = 4'd8;  end
            4'd8:  begin w.op = OP_ERRCHR; w.pos = 3'd3; w.chr = CHR_R; w.next = 4'd9;  end
            4'd9:  begin w.op = OP_ERRCHR; w.pos = 3'd4; w.chr = CHR_O; w.next = S_END; end
            S_END:
            begin
                w.op = OP_ERRCHR; w.pos = 3'd5; w.chr = CHR_R; w.last = 1'b1;
            end
            default: w.op = OP_WAIT;
        endcase
        return w;
    endfunction

    // Segment tables, padded to a power of two
    localparam logic [7:0] UP_DIGIT [16] = '{
        8'hF5, 8'h60, 8'hB6, 8'hF2, 8'h63, 8'hD3, 8'hD7, 8'h70, 8'hF7, 8'hF3,
        8'hF5, 8'hF5, 8'hF5, 8'hF5, 8'hF5, 8'hF5
    };
    localparam logic [7:0] LO_DIGIT [16] = '{
        8'h5D, 8'h06, 8'h6B, 8'h2F, 8'h36, 8'h3D, 8'h7D, 8'h07, 8'h7F, 8'h3F,
        8'h5D, 8'h5D, 8'h5D, 8'h5D, 8'h5D, 8'h5D
    };
    localparam logic [7:0] UP_LETTER [32] = '{
        8'h77, 8'hC7, 8'h95, 8'hE6, 8'h97, 8'h17, 8'hD5, 8'h67, 8'h14, 8'hE4,
        8'h57, 8'h85, 8'h56, 8'h46, 8'hC6, 8'h37, 8'h73, 8'h06, 8'hD1, 8'h87,
        8'hC4, 8'hA1, 8'hA3, 8'h44, 8'hE3, 8'hB4,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam logic [7:0] LO_LETTER [32] = '{
        8'h77, 8'h7C, 8'h59, 8'h6E, 8'h79, 8'h71, 8'h5D, 8'h76, 8'h41, 8'h4E,
        8'h75, 8'h58, 8'h65, 8'h64, 8'h6C, 8'h73, 8'h37, 8'h60, 8'h1D, 8'h78,
        8'h4C, 8'h1A, 8'h3A, 8'h44, 8'h3E, 8'h4B,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Digit pattern; anything above nine shows zero
    function automatic logic [7:0] seg_digit(input logic upper, input logic [16:0] d);
        logic [3:0] k;
        k = (d > 17'd9) ? 4'd0 : d[3:0];
        return upper ? UP_DIGIT[k] : LO_DIGIT[k];
    endfunction

    // Letter pattern; anything outside a..z is blank
    function automatic logic [7:0] seg_letter(input logic upper, input logic [16:0] c);
        logic [16:0] off;
        logic [7:0]  p;
        off = c - CHR_A_LO;
        p   = upper ? UP_LETTER[off[4:0]] : LO_LETTER[off[4:0]];
        if (c < CHR_A_LO || c > CHR_Z_LO)
            p = 8'h00;
        return p;
    endfunction

    // Position to segment memory offset; bad positions go to offset 1
    function automatic logic [3:0] slot_of(input logic upper, input logic [2:0] pos);
        logic [3:0] s;
        s = 4'd1;
        if (upper)
        begin
            if (pos >= 3'd1 && pos <= 3'd3)
                s = {1'b0, pos};
            else if (pos == 3'd4)
                s = 4'd5;
        end
        else if (pos >= 3'd1 && pos <= 3'd5)
        begin
            s = 4'd12 - {1'b0, pos};
        end
        return s;
    endfunction

endpackage

>>> rtl/segment_lcd_number_encoder_top.sv
// ----------------------------------------------------------------------------
// segment_lcd_number_encoder_top : segment LCD write encoder
// Turns digit, letter and decimal-number requests into byte writes for the
// segment memory of a two-line segment LCD, under a small microprogram.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries command, top_row, position
//   and value. Output channel (out_valid/out_ready) carries one segment
//   memory write per beat: mem_index (offset from base 0x0a00 + 0x20),
//   segments, and last on the final write of an item. Digit and letter
//   requests give one write; a number gives one write per decimal digit,
//   rightmost first, none for zero; an oversize number gives the five
//   letters of "error" on the lower line; command 3 gives nothing.
//   The microprogram steps one ROM word a cycle, except while the wait
//   step has no input beat or a write step waits on the output register.
//   First write appears the cycle after its step runs. The output register
//   holds a finished write while the sequencer takes the next input beat;
//   a write step waits while that register is full and out_ready is low.
//   in_ready is high only in the wait step.
//   Reset clears the step counter and the output valid flag; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module segment_lcd_number_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic        top_row,
    input  logic [2:0]  position,
    input  logic [16:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  mem_index,
    output logic [7:0]  segments,
    output logic        last
);

    logic [3:0]  step_reg, step_next;
    logic        upper_reg, upper_next;
    logic [2:0]  pos_reg, pos_next;
    logic [16:0] val_reg, val_next;
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  seg_reg, seg_next;
    logic        last_reg, last_next;

    slne_pkg::ucode_t ctl;
    logic        emit_ok;
    logic        advance;
    logic        cond_hit;
    logic        over;
    logic        done;
    logic [36:0] prod;
    logic [16:0] quot;
    logic [16:0] rem;

    // Current control word
    assign ctl = slne_pkg::ucode_rom(step_reg);

    // Output register is free when empty or being drained
    assign emit_ok = !out_valid_reg || out_ready;

    // Divide by ten through reciprocal multiply
    assign prod = 37'(val_reg) * 37'(slne_pkg::DIV10_MAGIC);
    assign quot = prod[slne_pkg::DIV10_SHIFT +: 14] == 14'd0 ? 17'd0
                : 17'(prod[slne_pkg::DIV10_SHIFT +: 14]);
    assign rem  = val_reg - ((quot << 3) + (quot << 1));

    // Branch conditions
    assign over = upper_reg ? (val_reg > slne_pkg::UPPER_MAX)
                            : (val_reg > slne_pkg::LOWER_MAX);
    assign done = (quot == 17'd0) || (pos_reg == 3'd1);

    always_comb
    begin
        case (ctl.cond)
            slne_pkg::COND_OVER: cond_hit = over;
            slne_pkg::COND_ZERO: cond_hit = (val_reg == 17'd0);
            slne_pkg::COND_DONE: cond_hit = done;
            default:             cond_hit = 1'b0;
        endcase
    end

    assign in_ready = (ctl.op == slne_pkg::OP_WAIT);

    // Sequencer and datapath next values
    always_comb
    begin
        step_next      = step_reg;
        upper_next     = upper_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && !out_ready;
        idx_next       = idx_reg;
        seg_next       = seg_reg;
        last_next      = last_reg;
        advance        = 1'b0;

        unique case (ctl.op)
            slne_pkg::OP_WAIT:
            begin
                if (in_valid)
                begin
                    upper_next = top_row;
                    pos_next   = position;
                    val_next   = value;
                    case (command)
                        slne_pkg::CMD_DIGIT:  step_next = slne_pkg::S_DIGIT;
                        slne_pkg::CMD_LETTER: step_next = slne_pkg::S_LETTER;
                        slne_pkg::CMD_NUMBER: step_next = slne_pkg::S_OVER;
                        default:              step_next = slne_pkg::S_WAIT;
                    endcase
                end
            end
            slne_pkg::OP_DIGIT:
            begin
                advance = emit_ok;
                idx_next = slne_pkg::slot_of(upper_reg, pos_reg);
                seg_next = slne_pkg::seg_digit(upper_reg, val_reg);
                last_next = ctl.last;
            end
            slne_pkg::OP_LETTER:
            begin
                advance = emit_ok;
                idx_next = slne_pkg::slot_of(upper_reg, pos_reg);
                seg_next = slne_pkg::seg_letter(upper_reg, val_reg);
                last_next = ctl.last;
            end
            slne_pkg::OP_TEST:
            begin
                advance  = 1'b1;
                pos_next = upper_reg ? 3'd4 : 3'd5;
            end
            slne_pkg::OP_NUMDIG:
            begin
                advance = emit_ok;
                idx_next = slne_pkg::slot_of(upper_reg, pos_reg);
                seg_next = slne_pkg::seg_digit(upper_reg, rem);
                last_next = done;
                if (emit_ok)
                begin
                    val_next = quot;
                    pos_next = pos_reg - 3'd1;
                end
            end
            slne_pkg::OP_ERRCHR:
            begin
                advance = emit_ok;
                idx_next = slne_pkg::slot_of(1'b0, ctl.pos);
                seg_next = slne_pkg::seg_letter(1'b0, 17'(ctl.chr));
                last_next = ctl.last;
            end
            default:
            begin
                advance = 1'b0;
            end
        endcase

        // Write steps hold the output register only when they fire
        if (ctl.op != slne_pkg::OP_WAIT && ctl.op != slne_pkg::OP_TEST)
        begin
            if (emit_ok)
                out_valid_next = 1'b1;
            else
            begin
                idx_next  = idx_reg;
                seg_next  = seg_reg;
                last_next = last_reg;
            end
        end

        if (advance)
            step_next = cond_hit ? ctl.jump : ctl.next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= slne_pkg::S_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        upper_reg <= upper_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        idx_reg   <= idx_next;
        seg_reg   <= seg_next;
        last_reg  <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign mem_index = idx_reg;
    assign segments  = seg_reg;
    assign last      = last_reg;

    // Checks
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= slne_pkg::S_END)
        else $error("step counter left the program");

    a_none_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == slne_pkg::CMD_NONE |=> step_reg == slne_pkg::S_WAIT)
        else $error("unused command did not return to wait");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.op != slne_pkg::OP_WAIT && ctl.op != slne_pkg::OP_TEST && emit_ok && last_next
        |=> step_reg == slne_pkg::S_WAIT)
        else $error("sequencer kept running after the final write");

    a_numdig_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == slne_pkg::S_NUMDIG |-> val_reg <= slne_pkg::LOWER_MAX
        && pos_reg >= 3'd1 && pos_reg <= 3'd5)
        else $error("digit step with value or position out of range");

endmodule

>>> verif/tb_segment_lcd_number_encoder_top.sv
// ----------------------------------------------------------------------------
// tb_segment_lcd_number_encoder_top : self-checking bench for the LCD encoder
// Sends digit, letter, number and unused requests through the input channel.
// The sender idles in random bursts and the receiver stalls to random
// patterns, with one long hold-off every so often. A local encoder works out
// the segment memory writes that each accepted beat should cause. Each output
// beat is compared field by field against the oldest pending write.
// ----------------------------------------------------------------------------
module tb_segment_lcd_number_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT     = 2000;   // cycles with no beat on either side
    localparam int HOLD_CYCLES    = 150;    // long receiver hold-off
    localparam int HOLD_PERIOD    = 1200;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_ITEMS   = 406;

    // Segment patterns per line
    localparam logic [7:0] UPPER_DIGIT_SEG [10] = '{
        8'hF5, 8'h60, 8'hB6, 8'hF2, 8'h63, 8'hD3, 8'hD7, 8'h70, 8'hF7, 8'hF3
    };
    localparam logic [7:0] LOWER_DIGIT_SEG [10] = '{
        8'h5D, 8'h06, 8'h6B, 8'h2F, 8'h36, 8'h3D, 8'h7D, 8'h07, 8'h7F, 8'h3F
    };
    localparam logic [7:0] UPPER_LETTER_SEG [26] = '{
        8'h77, 8'hC7, 8'h95, 8'hE6, 8'h97, 8'h17, 8'hD5, 8'h67, 8'h14, 8'hE4,
        8'h57, 8'h85, 8'h56, 8'h46, 8'hC6, 8'h37, 8'h73, 8'h06, 8'hD1, 8'h87,
        8'hC4, 8'hA1, 8'hA3, 8'h44, 8'hE3, 8'hB4
    };
    localparam logic [7:0] LOWER_LETTER_SEG [26] = '{
        8'h77, 8'h7C, 8'h59, 8'h6E, 8'h79, 8'h71, 8'h5D, 8'h76, 8'h41, 8'h4E,
        8'h75, 8'h58, 8'h65, 8'h64, 8'h6C, 8'h73, 8'h37, 8'h60, 8'h1D, 8'h78,
        8'h4C, 8'h1A, 8'h3A, 8'h44, 8'h3E, 8'h4B
    };
    // Overflow word, shown on the lower line
    localparam logic [16:0] OVERFLOW_WORD [5] = '{
        17'h65, 17'h72, 17'h72, 17'h6F, 17'h72
    };
    localparam logic [16:0] ASCII_A = 17'h61;
    localparam logic [16:0] ASCII_Z = 17'h7A;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        upper;
        logic [2:0]  pos;
        logic [16:0] val;
    } lcd_req_t;

    typedef struct packed {
        logic [3:0] idx;
        logic [7:0] seg;
        logic       fin;
    } lcd_write_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_TOGGLE
    } ready_mode_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [1:0]  command    = slne_pkg::CMD_DIGIT;
    logic        top_row    = 1'b0;
    logic [2:0]  position   = 3'd0;
    logic [16:0] value      = 17'd0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [3:0]  mem_index;
    logic [7:0]  segments;
    logic        last;

    lcd_req_t    request_queue [$];
    lcd_write_t  pending_writes [$];
    int          error_count = 0;

    segment_lcd_number_encoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .top_row    (top_row),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mem_index  (mem_index),
        .segments   (segments),
        .last       (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------
    function automatic logic [3:0] slot_offset(input logic upper, input int pos);
        if (upper)
        begin
            if (pos >= 1 && pos <= 3)
                return 4'(pos);
            if (pos == 4)
                return 4'd5;
            return 4'd1;
        end
        if (pos >= 1 && pos <= 5)
            return 4'(12 - pos);
        return 4'd1;
    endfunction

    function automatic logic [7:0] digit_segs(input logic upper, input logic [16:0] d);
        int k;
        k = (d > 17'd9) ? 0 : int'(d);
        return upper ? UPPER_DIGIT_SEG[k] : LOWER_DIGIT_SEG[k];
    endfunction

    function automatic logic [7:0] letter_segs(input logic upper, input logic [16:0] c);
        int k;
        if (c < ASCII_A || c > ASCII_Z)
            return 8'h00;
        k = int'(c - ASCII_A);
        return upper ? UPPER_LETTER_SEG[k] : LOWER_LETTER_SEG[k];
    endfunction

    // Append the writes one accepted request should produce
    task automatic encode_request(input lcd_req_t r);
        lcd_write_t w [$];
        int         rem;
        int         p;
        int         limit;
        case (r.cmd)
            slne_pkg::CMD_DIGIT:
                w.push_back('{slot_offset(r.upper, r.pos), digit_segs(r.upper, r.val), 1'b0});
            slne_pkg::CMD_LETTER:
                w.push_back('{slot_offset(r.upper, r.pos), letter_segs(r.upper, r.val), 1'b0});
            slne_pkg::CMD_NUMBER:
            begin
                limit = r.upper ? 9999 : 99999;
                if (int'(r.val) > limit)
                begin
                    for (int i = 0; i < 5; i++)
                        w.push_back('{slot_offset(1'b0, i + 1),
                                      letter_segs(1'b0, OVERFLOW_WORD[i]), 1'b0});
                end
                else
                begin
                    // rightmost digit first, stop once nothing is left
                    rem = int'(r.val);
                    p   = r.upper ? 4 : 5;
                    while (rem != 0 && p >= 1)
                    begin
                        w.push_back('{slot_offset(r.upper, p),
                                      digit_segs(r.upper, 17'(rem % 10)), 1'b0});
                        rem = rem / 10;
                        p--;
                    end
                end
            end
            default: ;
        endcase
        if (w.size() > 0)
            w[w.size() - 1].fin = 1'b1;
        foreach (w[i])
            pending_writes.push_back(w[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_request(input logic [1:0] cmd, input logic upper,
                               input logic [2:0] pos, input logic [16:0] val);
        request_queue.push_back('{cmd, upper, pos, val});
    endtask

    function automatic lcd_req_t make_random_request();
        lcd_req_t r;
        int       sel;
        int       ndig;
        int       lo;
        int       hi;
        sel     = $urandom_range(0, 99);
        r.upper = 1'($urandom_range(0, 1));
        r.pos   = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(1, 5));
        if (sel < 25)
        begin
            r.cmd = slne_pkg::CMD_DIGIT;
            r.val = ($urandom_range(0, 9) < 8) ? 17'($urandom_range(0, 12)) : 17'($urandom);
        end
        else if (sel < 50)
        begin
            r.cmd = slne_pkg::CMD_LETTER;
            r.val = ($urandom_range(0, 9) < 8) ? 17'($urandom_range(17'h5F, 17'h7C))
                                               : 17'($urandom);
        end
        else if (sel < 95)
        begin
            r.cmd = slne_pkg::CMD_NUMBER;
            ndig  = $urandom_range(0, 7);
            if (ndig == 0)
                r.val = 17'd0;
            else if (ndig == 7)
                r.val = 17'($urandom);
            else
            begin
                lo = 1;
                for (int i = 1; i < ndig; i++)
                    lo = lo * 10;
                hi = lo * 10 - 1;
                if (hi > 131071)
                    hi = 131071;
                r.val = 17'($urandom_range(lo, hi));
            end
        end
        else
        begin
            r.cmd = slne_pkg::CMD_NONE;
            r.val = 17'($urandom);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input lcd_write_t want);
        error_count++;
        $display("%0t: %s: got idx=%0d seg=%02h last=%0b, want idx=%0d seg=%02h last=%0b",
                 $realtime, what, mem_index, segments, last, want.idx, want.seg, want.fin);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the head of the request queue in bursts
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            command    <= slne_pkg::CMD_DIGIT;
            top_row    <= 1'b0;
            position   <= 3'd0;
            value      <= 17'd0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                encode_request('{command, top_row, position, value});
                request_queue.delete(0);
            end
            // a beat still waiting keeps valid and payload as they are
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    command    <= request_queue[0].cmd;
                    top_row    <= request_queue[0].upper;
                    position   <= request_queue[0].pos;
                    value      <= request_queue[0].val;
                    in_valid   <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall patterns plus a periodic long hold-off
    // ------------------------------------------------------------------
    int          rx_cycle  = 0;
    int          hold_left = 0;
    int          mode_left = 0;
    ready_mode_t rx_mode   = READY_ALWAYS;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_cycle  = 0;
            hold_left = 0;
            mode_left = 0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle % HOLD_PERIOD == 300)
                hold_left = HOLD_CYCLES;
            if (mode_left == 0)
            begin
                rx_mode   = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 80);
            end
            else
            begin
                mode_left--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_HALF:   out_ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:      out_ready <= ~out_ready;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each output beat against the oldest pending write
    // ------------------------------------------------------------------
    lcd_write_t want_write;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_writes.size() == 0)
            begin
                report_mismatch("write with nothing pending", '0);
            end
            else
            begin
                want_write = pending_writes.pop_front();
                if (mem_index !== want_write.idx || segments !== want_write.seg ||
                    last !== want_write.fin)
                    report_mismatch("write differs", want_write);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no beat on either side for too long
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("%0t: watchdog expired, %0d requests and %0d writes outstanding",
                             $realtime, request_queue.size(), pending_writes.size());
                    $display("** segment_lcd_number_encoder_top: FAILED **");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        // directed: table extremes, bad positions, number corner cases
        add_request(slne_pkg::CMD_DIGIT,  1'b1, 3'd1, 17'd0);
        add_request(slne_pkg::CMD_DIGIT,  1'b0, 3'd5, 17'd9);
        add_request(slne_pkg::CMD_DIGIT,  1'b1, 3'd4, 17'd10);        // above nine
        add_request(slne_pkg::CMD_DIGIT,  1'b0, 3'd0, 17'h1FFFF);     // bad position
        add_request(slne_pkg::CMD_DIGIT,  1'b1, 3'd5, 17'd7);         // bad position on upper
        add_request(slne_pkg::CMD_LETTER, 1'b1, 3'd4, 17'h61);
        add_request(slne_pkg::CMD_LETTER, 1'b0, 3'd1, 17'h7A);
        add_request(slne_pkg::CMD_LETTER, 1'b1, 3'd2, 17'h60);        // just below range
        add_request(slne_pkg::CMD_LETTER, 1'b0, 3'd3, 17'h7B);        // just above range
        add_request(slne_pkg::CMD_LETTER, 1'b0, 3'd4, 17'h10061);     // high bits set
        add_request(slne_pkg::CMD_LETTER, 1'b0, 3'd7, 17'h6D);        // bad position on lower
        add_request(slne_pkg::CMD_LETTER, 1'b1, 3'd6, 17'h71);
        add_request(slne_pkg::CMD_NUMBER, 1'b1, 3'd0, 17'd0);         // zero writes nothing
        add_request(slne_pkg::CMD_NUMBER, 1'b0, 3'd2, 17'd0);
        add_request(slne_pkg::CMD_NUMBER, 1'b1, 3'd0, 17'd9999);
        add_request(slne_pkg::CMD_NUMBER, 1'b1, 3'd0, 17'd10000);     // too large for upper
        add_request(slne_pkg::CMD_NUMBER, 1'b0, 3'd0, 17'd99999);
        add_request(slne_pkg::CMD_NUMBER, 1'b0, 3'd0, 17'd100000);    // too large for lower
        add_request(slne_pkg::CMD_NUMBER, 1'b1, 3'd7, 17'h1FFFF);
        add_request(slne_pkg::CMD_NUMBER, 1'b1, 3'd0, 17'd1000);      // inner zeros
        add_request(slne_pkg::CMD_NUMBER, 1'b0, 3'd0, 17'd7);
        add_request(slne_pkg::CMD_NONE,   1'b1, 3'd7, 17'h1FFFF);     // unused command
        add_request(slne_pkg::CMD_NONE,   1'b0, 3'd0, 17'd0);
        add_request(slne_pkg::CMD_DIGIT,  1'b0, 3'd3, 17'd5);

        // random part
        for (int i = 0; i < RANDOM_ITEMS; i++)
            request_queue.push_back(make_random_request());

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_writes.size() == 0)
            $display("** segment_lcd_number_encoder_top: PASSED **");
        else
            $display("** segment_lcd_number_encoder_top: FAILED **");
        $finish;
    end

endmodule

>>> segment_lcd_number_encoder_top.f
rtl/slne_pkg.sv
rtl/segment_lcd_number_encoder_top.sv
verif/tb_segment_lcd_number_encoder_top.sv
